[hdl/etf_pkg.sv]
// ----------------------------------------------------------------------------
// etf_pkg: shared types and constants of the escape-time fractal pixel unit
// Payload structs of the channels, configuration register indexes and the
// fixed constants of the iteration engine.
// ----------------------------------------------------------------------------
package etf_pkg;

  localparam int CFG_DATA_W = 64;
  localparam int DIGIT_W    = 16;
  localparam int IDX_W      = 12;
  localparam logic [12:0] BUDGET_MAX = 13'd4096;

  typedef enum logic [2:0] {
    REG_MAX_ITERATIONS    = 3'd0,
    REG_ORIGIN_X          = 3'd1,
    REG_ORIGIN_Y          = 3'd2,
    REG_STEP              = 3'd3,
    REG_JULIA_RE          = 3'd4,
    REG_JULIA_IM          = 3'd5,
    REG_COLOR_MULTIPLIERS = 3'd6,
    REG_JULIA_MODE        = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]            reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [15:0] pass_index;
    logic [15:0] color_offset;
    logic [7:0]  prev_red;
    logic [7:0]  prev_green;
    logic [7:0]  prev_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] escape_count;
  } pixel_out_t;

  // Per-pixel data that rides along with the coordinates.
  typedef struct packed {
    logic [15:0] pass_index;
    logic [15:0] color_offset;
    logic [7:0]  prev_red;
    logic [7:0]  prev_green;
    logic [7:0]  prev_blue;
  } meta_t;

  // Iteration and coloring controls handed to the back end.
  typedef struct packed {
    logic [12:0] max_iterations;
    logic [23:0] color_multipliers;
    logic        julia_mode;
  } iter_cfg_t;

endpackage

[hdl/etf_stream_if.sv]
// ----------------------------------------------------------------------------
// etf_stream_if: valid/ready channel
// Carries one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface etf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/etf_front.sv]
// ----------------------------------------------------------------------------
// etf_front: pixel intake and coordinate mapping
// Clamps the indexes, multiplies them by the step and adds the origin with
// saturation, in a two-stage pipeline.
// ----------------------------------------------------------------------------
module etf_front #(
  parameter int W       = 48,
  parameter int MAX_DIM = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  etf_pkg::pixel_in_t    pix_i,
  input  logic signed [W-1:0]   origin_x_i,
  input  logic signed [W-1:0]   origin_y_i,
  input  logic [W-2:0]          step_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [2*W+55:0]       item_o
);
  import etf_pkg::*;

  localparam int PW = IDX_W + W - 1;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = s[W] ? MINV : MAXV;
    else sat_add = s[W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] clamp(input logic [IDX_W-1:0] idx);
    if (32'(idx) >= 32'(MAX_DIM)) clamp = IDX_W'(MAX_DIM - 1);
    else clamp = idx;
  endfunction

  function automatic logic [W-2:0] sat_prod(input logic [PW-1:0] p);
    if (|p[PW-1:W-1]) sat_prod = {(W-1){1'b1}};
    else sat_prod = p[W-2:0];
  endfunction

  logic          s1_v_q, s1_v_d;
  logic [PW-1:0] px_prod_q, py_prod_q;
  meta_t         s1_meta_q;
  logic          out_v_q, out_v_d;
  logic [2*W+55:0] out_q;
  logic          adv2;
  logic signed [W-1:0] px, py;

  assign adv2    = !out_v_q || ready_i;
  assign ready_o = !s1_v_q || adv2;
  assign s1_v_d  = ready_o ? valid_i : s1_v_q;
  assign out_v_d = adv2 ? s1_v_q : out_v_q;

  assign px = sat_add(origin_x_i, {1'b0, sat_prod(px_prod_q)});
  assign py = sat_add(origin_y_i, {1'b0, sat_prod(py_prod_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      px_prod_q <= clamp(pix_i.column) * step_i;
      py_prod_q <= clamp(pix_i.row) * step_i;
      s1_meta_q <= '{pass_index: pix_i.pass_index, color_offset: pix_i.color_offset,
                     prev_red: pix_i.prev_red, prev_green: pix_i.prev_green,
                     prev_blue: pix_i.prev_blue};
    end
    if (adv2 && s1_v_q) begin
      out_q <= {px, py, s1_meta_q};
    end
  end

  assign valid_o = out_v_q;
  assign item_o  = out_q;

endmodule

[hdl/etf_queue.sv]
// ----------------------------------------------------------------------------
// etf_queue: two-entry queue
// Decouples the coordinate front end from the iteration back end.
// ----------------------------------------------------------------------------
module etf_queue #(
  parameter int WIDTH = 152
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

endmodule

[hdl/etf_mul.sv]
// ----------------------------------------------------------------------------
// etf_mul: multi-cycle fixed-point multiplier
// Multiplies magnitudes one 16-bit digit per cycle, then drops the fraction
// bits rounding toward minus infinity and saturates.
// ----------------------------------------------------------------------------
module etf_mul #(
  parameter int W = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic                done_o,
  output logic signed [W-1:0] p_o
);
  import etf_pkg::*;

  localparam int NSTEP = (W + DIGIT_W - 1) / DIGIT_W;
  localparam int NB    = NSTEP * DIGIT_W;
  localparam int CW    = $clog2(NSTEP + 1);
  localparam int F     = W - 4;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0]   ma_q;
  logic [NB-1:0]  mb_q;
  logic           neg_q;
  logic [2*W-1:0] acc_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, fin_q, done_q;
  logic signed [W-1:0] p_q, res;
  logic [W+3:0]   q;
  logic           rem_nz, ovf;
  logic [W-1:0]   qi;

  assign q      = acc_q[2*W-1:F];
  assign rem_nz = |acc_q[F-1:0];
  assign ovf    = |q[W+3:W-1];
  assign qi     = q[W-1:0] + W'(rem_nz);

  always_comb begin
    if (!neg_q) res = ovf ? MAXV : q[W-1:0];
    else res = ovf ? MINV : -qi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NSTEP);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_i[W-1] ? -a_i : a_i;
      mb_q  <= NB'($unsigned(b_i[W-1] ? -b_i : b_i));
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {acc_q[2*W-DIGIT_W-1:0], {DIGIT_W{1'b0}}}
             + (2*W)'(ma_q) * (2*W)'(mb_q[NB-1 -: DIGIT_W]);
      mb_q  <= {mb_q[NB-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
    if (fin_q) p_q <= res;
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

[hdl/etf_back.sv]
// ----------------------------------------------------------------------------
// etf_back: iteration engine, coloring and pass blending
// Runs z <- z^2 + c through one shared multiplier, colors the escape count
// and divides the blended sums bit by bit.
// ----------------------------------------------------------------------------
module etf_back #(
  parameter int W = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [2*W+55:0]      item_i,
  input  etf_pkg::iter_cfg_t   cfg_i,
  input  logic signed [W-1:0]  julia_re_i,
  input  logic signed [W-1:0]  julia_im_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output etf_pkg::pixel_out_t  res_o
);
  import etf_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_JXX   = 4'd1;
  localparam logic [3:0] ST_JYY   = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_XY    = 4'd4;
  localparam logic [3:0] ST_YY    = 4'd5;
  localparam logic [3:0] ST_XX    = 4'd6;
  localparam logic [3:0] ST_COLOR = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0] FOUR = (W+1)'(1) << (W - 2);

  function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sat_add = s[W] ? MINV : MAXV;
    else sat_add = s[W-1:0];
  endfunction

  logic [3:0]          state_q, state_d;
  logic signed [W-1:0] x_q, y_q, cx_q, cy_q, xx_q, yy_q, t_q;
  logic [12:0]         cnt_q, budget_q;
  logic [11:0]         count_q;
  meta_t               meta_q;
  logic [23:0]         rem_q [3];
  logic [7:0]          quot_q [3];
  logic [23:0]         dsh_q;
  logic [16:0]         div_q;
  logic [2:0]          dstep_q;
  logic                issued_q;
  logic                out_v_q;
  pixel_out_t          out_q;

  logic                mul_state, mul_start, mul_done;
  logic signed [W-1:0] mul_a, mul_b, mul_p;
  logic signed [W-1:0] in_px, in_py;
  meta_t               in_meta;
  logic [12:0]         budget;
  logic                escaped, load_out;
  logic [16:0]         den;
  logic [7:0]          prev [3];
  logic [7:0]          mult [3];
  logic [7:0]          sum8;

  assign {in_px, in_py, in_meta} = item_i;
  assign budget  = (cfg_i.max_iterations > BUDGET_MAX) ? BUDGET_MAX : cfg_i.max_iterations;
  assign escaped = ({1'b0, xx_q} + {1'b0, yy_q}) >= FOUR;
  assign ready_o = (state_q == ST_IDLE);
  assign load_out = (state_q == ST_OUT) && (!out_v_q || ready_i);

  assign mul_state = (state_q == ST_JXX) || (state_q == ST_JYY) || (state_q == ST_XY)
                  || (state_q == ST_YY) || (state_q == ST_XX);
  assign mul_start = mul_state && !issued_q;
  assign mul_a = ((state_q == ST_JYY) || (state_q == ST_YY)) ? y_q : x_q;
  assign mul_b = ((state_q == ST_JXX) || (state_q == ST_XX)) ? x_q : y_q;

  etf_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign den     = {1'b0, meta_q.pass_index} + 17'd1;
  assign prev[0] = meta_q.prev_red;
  assign prev[1] = meta_q.prev_green;
  assign prev[2] = meta_q.prev_blue;
  assign mult[0] = cfg_i.color_multipliers[7:0];
  assign mult[1] = cfg_i.color_multipliers[15:8];
  assign mult[2] = cfg_i.color_multipliers[23:16];
  assign sum8    = count_q[7:0] + meta_q.color_offset[7:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (valid_i) state_d = (budget < 13'd2) ? ST_CHECK
                                     : (cfg_i.julia_mode ? ST_JXX : ST_CHECK);
      ST_JXX:   if (mul_done) state_d = ST_JYY;
      ST_JYY:   if (mul_done) state_d = ST_CHECK;
      ST_CHECK: state_d = ((cnt_q == '0) || escaped) ? ST_COLOR : ST_XY;
      ST_XY:    if (mul_done) state_d = ST_YY;
      ST_YY:    if (mul_done) state_d = ST_XX;
      ST_XX:    if (mul_done) state_d = ST_CHECK;
      ST_COLOR: state_d = ST_DIV;
      ST_DIV:   if (dstep_q == 3'd7) state_d = ST_OUT;
      ST_OUT:   if (load_out) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start) issued_q <= 1'b1;
      else if (mul_done) issued_q <= 1'b0;
      if (load_out) out_v_q <= 1'b1;
      else if (ready_i) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          meta_q   <= in_meta;
          budget_q <= budget;
          cnt_q    <= (budget < 13'd2) ? 13'd0 : budget - 13'd1;
          if (cfg_i.julia_mode) begin
            x_q  <= in_px;
            y_q  <= in_py;
            cx_q <= julia_re_i;
            cy_q <= julia_im_i;
          end else begin
            x_q  <= '0;
            y_q  <= '0;
            cx_q <= in_px;
            cy_q <= in_py;
          end
          xx_q <= '0;
          yy_q <= '0;
        end
      end
      ST_JXX: if (mul_done) xx_q <= mul_p;
      ST_JYY: if (mul_done) yy_q <= mul_p;
      ST_CHECK: begin
        count_q <= (cnt_q != '0) ? 12'(budget_q - cnt_q) : 12'd0;
        t_q     <= sat_add(xx_q, -yy_q);
      end
      ST_XY: begin
        if (mul_done) begin
          y_q <= sat_add(sat_add(mul_p, mul_p), cy_q);
          x_q <= sat_add(t_q, cx_q);
        end
      end
      ST_YY: if (mul_done) yy_q <= mul_p;
      ST_XX: begin
        if (mul_done) begin
          xx_q  <= mul_p;
          cnt_q <= cnt_q - 13'd1;
        end
      end
      ST_COLOR: begin
        for (int k = 0; k < 3; k++) begin
          rem_q[k] <= 24'(prev[k]) * 24'(meta_q.pass_index)
                    + 24'((count_q == '0) ? 8'd0 : 8'(sum8 * mult[k]))
                    + 24'(den[16:1]);
        end
        div_q   <= den;
        dsh_q   <= {den, 7'd0};
        dstep_q <= 3'd0;
      end
      ST_DIV: begin
        for (int k = 0; k < 3; k++) begin
          if (rem_q[k] >= dsh_q) begin
            rem_q[k]  <= rem_q[k] - dsh_q;
            quot_q[k] <= {quot_q[k][6:0], 1'b1};
          end else begin
            quot_q[k] <= {quot_q[k][6:0], 1'b0};
          end
        end
        dsh_q   <= dsh_q >> 1;
        dstep_q <= dstep_q + 3'd1;
      end
      ST_OUT: begin
        if (load_out) begin
          out_q <= '{red: quot_q[0], green: quot_q[1], blue: quot_q[2],
                     escape_count: count_q};
        end
      end
      default: ;
    endcase
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;

  // A product only comes back for a request this engine made.
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> issued_q) else $error("multiplier result without request");

  // The remaining budget never exceeds the budget the pixel started with.
  a_cnt_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) |-> (cnt_q <= budget_q)) else $error("counter above budget");

  // Taking a pixel from the queue always starts work on it.
  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> (state_q != ST_IDLE)) else $error("pixel dropped");

  // After the last division step every remainder lies below the divisor.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) |-> ((rem_q[0] < 24'(div_q)) && (rem_q[1] < 24'(div_q))
                             && (rem_q[2] < 24'(div_q))))
    else $error("blend division left a remainder too large");

endmodule

[hdl/escape_time_fractal_pixel_unit.sv]
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_unit: Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to a fixed-point point, iterates it, colors the escape count
// and blends the color into the previous pass.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i carries register writes (index and data); it is always ready. Write
//   registers only while no pixel is in flight.
//   pix_i takes one pixel per transaction; pix_o returns one colored pixel per
//   input transaction, in order.
//   Timing: the front end registers a pixel in stage 1 and in its output
//   register, the queue stores it once, and the back end then runs each
//   iteration as a check and three products (xy, yy, xx) on the shared
//   digit-serial multiplier, with NSTEP = COORD_WIDTH/16 digits (rounded up)
//   per product, plus setup, coloring and an 8-step division (and the two
//   starting squares in Julia mode). The shared multiplier sets the pace.
//   The front end and the two-entry queue keep taking pixels while the back
//   end iterates, so up to six pixels can be held inside.
//   A stalled pix_o holds its result; the back end then waits and the front
//   end fills up before pix_i drops ready.
//   Reset returns all registers to their defaults (budget 256, the rest zero)
//   and empties every stage; no clearing pass is needed.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_unit #(
  parameter int COORD_WIDTH = 48,
  parameter int MAX_DIM     = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  etf_stream_if.sink    cfg_i,
  etf_stream_if.sink    pix_i,
  etf_stream_if.source  pix_o
);
  import etf_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int ITEM_W = 2 * W + 56;

  // Configuration registers.
  logic [12:0]         max_iter_q;
  logic signed [W-1:0] origin_x_q, origin_y_q, julia_re_q, julia_im_q;
  logic [W-2:0]        step_q;
  logic [23:0]         color_mult_q;
  logic                julia_mode_q;
  cfg_write_t          cfg_wr;
  iter_cfg_t           iter_cfg;

  // Front end to queue, queue to back end.
  logic              fe_valid, fe_ready, q_valid, q_ready;
  logic [ITEM_W-1:0] fe_item, q_item;

  assign cfg_wr      = cfg_i.data;
  assign cfg_i.ready = 1'b1;

  // Register writes land directly; every 3-bit index names a register, so
  // the default arm is never taken. Each register keeps only the bits it defines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q   <= 13'd256;
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      step_q       <= '0;
      julia_re_q   <= '0;
      julia_im_q   <= '0;
      color_mult_q <= '0;
      julia_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_wr.reg_index))
        REG_MAX_ITERATIONS:    max_iter_q   <= cfg_wr.wdata[12:0];
        REG_ORIGIN_X:          origin_x_q   <= cfg_wr.wdata[W-1:0];
        REG_ORIGIN_Y:          origin_y_q   <= cfg_wr.wdata[W-1:0];
        REG_STEP:              step_q       <= cfg_wr.wdata[W-2:0];
        REG_JULIA_RE:          julia_re_q   <= cfg_wr.wdata[W-1:0];
        REG_JULIA_IM:          julia_im_q   <= cfg_wr.wdata[W-1:0];
        REG_COLOR_MULTIPLIERS: color_mult_q <= cfg_wr.wdata[23:0];
        REG_JULIA_MODE:        julia_mode_q <= cfg_wr.wdata[0];
        default: ;
      endcase
    end
  end

  assign iter_cfg = '{max_iterations: max_iter_q, color_multipliers: color_mult_q,
                      julia_mode: julia_mode_q};

  // The front end turns indexes into saturated coordinates.
  etf_front #(.W(W), .MAX_DIM(MAX_DIM)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pix_i.valid),
    .ready_o    (pix_i.ready),
    .pix_i      (pix_i.data),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .step_i     (step_q),
    .valid_o    (fe_valid),
    .ready_i    (fe_ready),
    .item_o     (fe_item)
  );

  // The queue lets the front end keep working while the back end iterates.
  etf_queue #(.WIDTH(ITEM_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .ready_o (fe_ready),
    .data_i  (fe_item),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_item)
  );

  // The back end iterates, colors and blends one pixel at a time.
  etf_back #(.W(W)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .ready_o    (q_ready),
    .item_i     (q_item),
    .cfg_i      (iter_cfg),
    .julia_re_i (julia_re_q),
    .julia_im_i (julia_im_q),
    .valid_o    (pix_o.valid),
    .ready_i    (pix_o.ready),
    .res_o      (pix_o.data)
  );

endmodule
